/* hdl/gsa_pkg.sv */
// ----------------------------------------------------------------------------
// gsa_pkg: shared types, constants and field functions for the GSA parser
// Holds the parse state, the record layout and the per-byte update rules.
// ----------------------------------------------------------------------------
`default_nettype none

package gsa_pkg;

  localparam int MAX_SATS  = 12;
  localparam int MAX_LEN   = 100;
  localparam int OUT_SATS  = 12;
  localparam int SAT_SLOTS = (MAX_SATS > OUT_SATS) ? MAX_SATS : OUT_SATS;
  localparam int SAT_CNT_W = $clog2(MAX_SATS + 1);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);

  // field numbers within the sentence
  localparam logic [4:0] FIELD_SEL       = 5'd1;
  localparam logic [4:0] FIELD_FIX       = 5'd2;
  localparam logic [4:0] FIELD_SAT_FIRST = 5'd3;
  localparam logic [4:0] FIELD_SAT_LAST  = 5'd14;
  localparam logic [4:0] FIELD_DOP_FIRST = 5'd15;
  localparam logic [4:0] FIELD_DOP_LAST  = 5'd17;
  localparam logic [4:0] FIELD_LAST      = 5'd18;
  localparam logic [4:0] FIELD_LIMIT     = 5'd19;

  localparam logic [19:0] NUM_CAP = 20'd255;
  localparam logic [19:0] DOP_CAP = 20'd65535;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef struct packed {
    logic [4:0]  fidx;
    logic        started;   // at least one byte taken in this field
    logic [15:0] acc;
    logic        stopped;
    logic [1:0]  frac;
    logic        dot;
  } parse_st_t;

  typedef struct packed {
    logic [7:0]                     sel;
    logic [7:0]                     fix;
    logic [SAT_CNT_W-1:0]           sat_n;
    logic [SAT_SLOTS-1:0][7:0]      sats;
    logic [2:0][15:0]               dop;
    logic                           err;
  } rec_t;

  typedef struct packed {
    parse_st_t p;
    rec_t      r;
  } full_st_t;

  // one byte request handed to the parse core
  typedef struct packed {
    logic       go;
    logic [7:0] char_byte;
    logic       last_byte;
  } step_t;

  function automatic logic is_dop(logic [4:0] fidx);
    return (fidx >= FIELD_DOP_FIRST) && (fidx <= FIELD_DOP_LAST);
  endfunction

  // close the current field into the record
  function automatic rec_t gsa_commit(rec_t r, parse_st_t p);
    rec_t        q;
    logic [22:0] v;
    q = r;
    v = '0;
    if (p.fidx == FIELD_FIX) begin
      q.fix = p.acc[7:0];
    end else if ((p.fidx >= FIELD_SAT_FIRST) && (p.fidx <= FIELD_SAT_LAST)) begin
      if ((p.acc != 16'd0) && (int'(r.sat_n) < MAX_SATS)) begin
        for (int i = 0; i < MAX_SATS; i++) begin
          if (int'(r.sat_n) == i) q.sats[i] = p.acc[7:0];
        end
        q.sat_n = SAT_CNT_W'(r.sat_n + 1'b1);
      end
    end else if (is_dop(p.fidx)) begin
      case (p.frac)
        2'd0:    v = 23'(p.acc) * 23'd100;
        2'd1:    v = 23'(p.acc) * 23'd10;
        default: v = 23'(p.acc);
      endcase
      if (v > 23'(DOP_CAP)) v = 23'(DOP_CAP);
      for (int k = 0; k < 3; k++) begin
        if (p.fidx == 5'(FIELD_DOP_FIRST + 5'(k))) q.dop[k] = v[15:0];
      end
    end
    return q;
  endfunction

  // apply one non-NUL byte to the parse state
  function automatic full_st_t gsa_take_byte(full_st_t s, logic [7:0] c);
    full_st_t    n;
    logic [19:0] t;
    logic        dop_f;
    n     = s;
    t     = 20'(s.p.acc) * 20'd10 + 20'(c[3:0]);
    dop_f = is_dop(s.p.fidx);
    if (c == CH_COMMA) begin
      n.r = gsa_commit(s.r, s.p);
      if (s.p.fidx < FIELD_LIMIT) n.p.fidx = s.p.fidx + 5'd1;
      if (n.p.fidx > FIELD_LAST) n.r.err = 1'b1;
      n.p.started = 1'b0;
      n.p.acc     = '0;
      n.p.stopped = 1'b0;
      n.p.frac    = '0;
      n.p.dot     = 1'b0;
    end else begin
      if ((s.p.fidx == FIELD_SEL) && !s.p.started) n.r.sel = c;
      n.p.started = 1'b1;
      if (!s.p.stopped) begin
        if ((c >= CH_0) && (c <= CH_9)) begin
          if (dop_f) begin
            if (!(s.p.dot && (s.p.frac >= 2'd2))) begin
              if (s.p.dot) n.p.frac = s.p.frac + 2'd1;
              n.p.acc = (t > DOP_CAP) ? DOP_CAP[15:0] : t[15:0];
            end
          end else begin
            n.p.acc = (t > NUM_CAP) ? NUM_CAP[15:0] : t[15:0];
          end
        end else if ((c == CH_DOT) && dop_f && !s.p.dot) begin
          n.p.dot = 1'b1;
        end else begin
          n.p.stopped = 1'b1;
        end
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* hdl/gsa_if.sv */
// ----------------------------------------------------------------------------
// gsa_in_if / gsa_out_if: valid-ready channels of the GSA parser
// Byte channel in, record channel out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;
  modport source(output valid, char_byte, last_byte, input ready);
  modport sink(input valid, char_byte, last_byte, output ready);
endinterface

interface gsa_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  selection_char;
  logic [7:0]  fix_type;
  logic [3:0]  sat_count;
  logic [47:0] sats_first_six;
  logic [47:0] sats_last_six;
  logic [15:0] pdop_centi;
  logic [15:0] hdop_centi;
  logic [15:0] vdop_centi;
  logic        too_many_fields;
  modport source(output valid, selection_char, fix_type, sat_count, sats_first_six,
                 sats_last_six, pdop_centi, hdop_centi, vdop_centi, too_many_fields,
                 input ready);
  modport sink(input valid, selection_char, fix_type, sat_count, sats_first_six,
               sats_last_six, pdop_centi, hdop_centi, vdop_centi, too_many_fields,
               output ready);
endinterface

`default_nettype wire

/* hdl/gsa_parse_core.sv */
// ----------------------------------------------------------------------------
// gsa_parse_core: sentence state and per-byte field update
// Holds field counter, number accumulator and record; gives the closed record.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_parse_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire gsa_pkg::step_t step_i,
  output gsa_pkg::rec_t      rec_o
);
  import gsa_pkg::*;

  full_st_t          st_r, st_nxt;
  logic [CNT_W-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic              text_end_r, text_end_nxt;
  logic              live;

  always_comb begin
    live         = !text_end_r && (byte_cnt_r < CNT_W'(MAX_LEN - 1));
    st_nxt       = st_r;
    text_end_nxt = text_end_r;
    if (live) begin
      if (step_i.char_byte == CH_NUL) text_end_nxt = 1'b1;
      else st_nxt = gsa_take_byte(st_r, step_i.char_byte);
    end
    byte_cnt_nxt = (byte_cnt_r < CNT_W'(MAX_LEN)) ? CNT_W'(byte_cnt_r + 1'b1) : byte_cnt_r;
    // final field closes on the sentence end
    rec_o = gsa_commit(st_nxt.r, st_nxt.p);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= '0;
      byte_cnt_r <= '0;
      text_end_r <= 1'b0;
    end else if (step_i.go) begin
      if (step_i.last_byte) begin
        st_r       <= '0;
        byte_cnt_r <= '0;
        text_end_r <= 1'b0;
      end else begin
        st_r       <= st_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        text_end_r <= text_end_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/nmea_gsa_sentence_parser.sv */
// ----------------------------------------------------------------------------
// nmea_gsa_sentence_parser: GSA sentence to fix record
// Splits a byte stream at commas and packs selection, fix, satellites, DOPs.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                   accepted when
//  in_if     in   char_byte, last_byte                      valid & ready
//  out_if    out  selection_char .. too_many_fields record  valid & ready
//
//  One byte per cycle sustained while no last byte waits on a busy out_if. A
//  byte is held in the input register, then the parse core updates its state;
//  out_if shows the record from the result register, loaded with its last byte.
//  Reset (rst_n low, synchronous) clears the sentence state and both valids.
//  A finished record waiting on out_if stalls only a later last byte; plain
//  bytes keep flowing through the parse core underneath it.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_gsa_sentence_parser (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gsa_in_if.sink      in_if,
  gsa_out_if.source   out_if
);
  import gsa_pkg::*;

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;

  // result register
  logic        out_valid_r;
  logic [7:0]  sel_r;
  logic [7:0]  fix_r;
  logic [3:0]  cnt_r;
  logic [47:0] first_r;
  logic [47:0] last_r;
  logic [15:0] pdop_r;
  logic [15:0] hdop_r;
  logic [15:0] vdop_r;
  logic        err_r;

  logic        out_free;
  logic        proc_go;
  step_t       step;
  rec_t        rec;
  logic [47:0] first_nxt;
  logic [47:0] last_nxt;
  logic [3:0]  cnt_nxt;

  // a last byte needs a free result slot; other bytes never wait
  assign out_free    = !out_valid_r || out_if.ready;
  assign proc_go     = s1_valid_r && (!s1_last_r || out_free);
  assign in_if.ready = !s1_valid_r || proc_go;

  assign step.go        = proc_go;
  assign step.char_byte = s1_char_r;
  assign step.last_byte = s1_last_r;

  gsa_parse_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .rec_o  (rec)
  );

  // pack the satellite list; slots at or past the count read zero
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      first_nxt[8*i +: 8] = (int'(rec.sat_n) > i) ? rec.sats[i] : 8'd0;
      last_nxt[8*i +: 8]  = (int'(rec.sat_n) > i + 6) ? rec.sats[i + 6] : 8'd0;
    end
    cnt_nxt = (int'(rec.sat_n) > OUT_SATS) ? 4'(OUT_SATS) : 4'(rec.sat_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) s1_valid_r <= in_if.valid;
      if (proc_go && s1_last_r) out_valid_r <= 1'b1;
      else if (out_if.ready)    out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready) begin
      s1_char_r <= in_if.char_byte;
      s1_last_r <= in_if.last_byte;
    end
    if (proc_go && s1_last_r) begin
      sel_r   <= rec.sel;
      fix_r   <= rec.fix;
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      pdop_r  <= rec.dop[0];
      hdop_r  <= rec.dop[1];
      vdop_r  <= rec.dop[2];
      err_r   <= rec.err;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.selection_char  = sel_r;
  assign out_if.fix_type        = fix_r;
  assign out_if.sat_count       = cnt_r;
  assign out_if.sats_first_six  = first_r;
  assign out_if.sats_last_six   = last_r;
  assign out_if.pdop_centi      = pdop_r;
  assign out_if.hdop_centi      = hdop_r;
  assign out_if.vdop_centi      = vdop_r;
  assign out_if.too_many_fields = err_r;

endmodule

`default_nettype wire

/* hdl/gsa_checker.sv */
// ----------------------------------------------------------------------------
// gsa_checker: port-level checks for the GSA parser
// Watches the record channel; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module gsa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  selection_char,
  input wire logic [3:0]  sat_count,
  input wire logic [47:0] sats_first_six,
  input wire logic [47:0] sats_last_six,
  input wire logic [15:0] pdop_centi
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("record request dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(sat_count) && $stable(sats_first_six)
      && $stable(selection_char) && $stable(pdop_centi))
    else $error("record payload changed while stalled");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> sat_count <= 4'd12)
    else $error("satellite count above twelve");

  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (sat_count <= 4'd6) |-> sats_last_six == 48'd0)
    else $error("upper satellite slots not cleared");

  a_lower_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (sat_count == 4'd0) |-> sats_first_six == 48'd0)
    else $error("lower satellite slots not cleared");

endmodule

bind nmea_gsa_sentence_parser gsa_checker u_gsa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .selection_char (out_if.selection_char),
  .sat_count      (out_if.sat_count),
  .sats_first_six (out_if.sats_first_six),
  .sats_last_six  (out_if.sats_last_six),
  .pdop_centi     (out_if.pdop_centi)
);

`default_nettype wire
